### rtl/rgbhsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// Shared widths, constants and the stage record for the rgb to hsl pipeline.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

    localparam int CH_W  = 8;    // pixel channel width, also divisor width
    localparam int QUO_W = 15;   // quotient bits, one per divider cell
    localparam int NUM_W = CH_W + QUO_W;
    localparam int OUT_W = 15;

    localparam int HUE_SIXTH = 3840;   // 60 degrees in 1/64 degree
    localparam int HUE_FULL  = 23040;  // 360 degrees
    localparam int PCT_SCALE = 25600;  // 100 percent in 1/256 percent

    // 12800/255 = 50 + 50/255, since 12800 = 50*256
    localparam int LIGHT_WHOLE = (PCT_SCALE / 2) / 255;

    // one request in flight between two cells; the *_w words hold
    // {partial remainder, numerator bits left, quotient bits so far}
    typedef struct packed {
        logic [NUM_W-1:0] hue_w;
        logic [NUM_W-1:0] sat_w;
        logic [OUT_W-1:0] lit;
        logic [CH_W-1:0]  hue_div;
        logic [CH_W-1:0]  sat_div;
        logic             gray;
    } stage_t;

endpackage

### rtl/rgbhsl_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsl_prep
// Front stage: max/min, lightness, numerators and divisors for the quotients.
// ----------------------------------------------------------------------------
module rgbhsl_prep (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [rgbhsl_pkg::CH_W-1:0]  red,
    input  logic [rgbhsl_pkg::CH_W-1:0]  green,
    input  logic [rgbhsl_pkg::CH_W-1:0]  blue,
    output logic                         out_valid,
    output rgbhsl_pkg::stage_t           out_data
);
    import rgbhsl_pkg::*;

    logic                 valid_reg;
    stage_t               data_reg;
    stage_t               data_next;

    logic                 red_max;
    logic                 green_max;
    logic [CH_W-1:0]      mx;
    logic [CH_W-1:0]      mn;
    logic [CH_W-1:0]      d;
    logic [CH_W:0]        s;
    logic [CH_W-1:0]      den;
    logic [15:0]          sector_mul;
    logic signed [CH_W:0] x_s;
    logic signed [23:0]   x_ext;
    logic signed [23:0]   offs;
    logic [NUM_W-1:0]     base;
    logic signed [23:0]   hue_sum;
    logic signed [23:0]   hue_num;
    logic [OUT_W-1:0]     lit_x;
    logic [OUT_W-1:0]     lit_q;

    always_comb
    begin
        red_max   = (red >= green) && (red >= blue);
        green_max = !red_max && (green >= blue);

        mx = red;
        if (green > mx)
        begin
            mx = green;
        end
        if (blue > mx)
        begin
            mx = blue;
        end
        mn = red;
        if (green < mn)
        begin
            mn = green;
        end
        if (blue < mn)
        begin
            mn = blue;
        end
        d = mx - mn;
        s = {1'b0, mx} + {1'b0, mn};

        // distance from mid-gray picks the saturation divisor
        if (s <= (CH_W+1)'(255))
        begin
            den = s[CH_W-1:0];
        end
        else
        begin
            den = CH_W'((CH_W+1)'(510) - s);
        end

        priority if (red_max)
        begin
            sector_mul = 16'd0;
            x_s = $signed({1'b0, green}) - $signed({1'b0, blue});
        end
        else if (green_max)
        begin
            sector_mul = 16'(2 * HUE_SIXTH);
            x_s = $signed({1'b0, blue}) - $signed({1'b0, red});
        end
        else
        begin
            sector_mul = 16'(4 * HUE_SIXTH);
            x_s = $signed({1'b0, red}) - $signed({1'b0, green});
        end

        x_ext   = 24'(x_s);
        offs    = x_ext * 24'sd3840;
        base    = NUM_W'({8'd0, sector_mul} * {16'd0, d});
        hue_sum = $signed({1'b0, base}) + offs;
        // wrap a negative hue into the top sector
        if (hue_sum < 0)
        begin
            hue_num = hue_sum + $signed(24'(HUE_FULL * d));
        end
        else
        begin
            hue_num = hue_sum;
        end

        // lightness = 50*s + floor(50*s/255); x/255 as (x + x/256 + 1)/256
        lit_x = OUT_W'(LIGHT_WHOLE * s);
        lit_q = (lit_x + (lit_x >> 8) + OUT_W'(1)) >> 8;

        data_next.hue_w   = NUM_W'(hue_num);
        data_next.sat_w   = NUM_W'(PCT_SCALE * d);
        data_next.lit     = lit_x + lit_q;
        data_next.hue_div = d;
        data_next.sat_div = den;
        data_next.gray    = (d == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/rgbhsl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsl_cell
// One restoring divider step on each of two lanes: one quotient bit each.
// ----------------------------------------------------------------------------
module rgbhsl_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  rgbhsl_pkg::stage_t in_data,
    output logic               out_valid,
    output rgbhsl_pkg::stage_t out_data
);
    import rgbhsl_pkg::*;

    logic   valid_reg;
    stage_t data_reg;
    stage_t data_next;

    function automatic logic [NUM_W-1:0] div_step(input logic [NUM_W-1:0] w,
                                                   input logic [CH_W-1:0]  dv);
        logic [CH_W:0] t;
        logic [CH_W:0] r;
        logic          ge;
        begin
            t  = {w[NUM_W-1:QUO_W], w[QUO_W-1]};
            ge = (t >= {1'b0, dv});
            r  = ge ? (t - {1'b0, dv}) : t;
            return {r[CH_W-1:0], w[QUO_W-2:0], ge};
        end
    endfunction

    always_comb
    begin
        data_next       = in_data;
        data_next.hue_w = div_step(in_data.hue_w, in_data.hue_div);
        data_next.sat_w = div_step(in_data.sat_w, in_data.sat_div);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/rgb_to_hsl_converter.sv
`timescale 1ns / 1ps
// a result passes the front stage register, then the 15 cell registers in order
// throughput: one pixel per cycle unless stalled; each cell: one quotient bit per lane
// a stalled output holds the whole pipeline; bubbles are not squeezed out
// reset clears the valid bit of every stage; payload registers are not reset
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter
// 8-bit RGB pixel to hue, saturation and lightness in fixed point.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rgbhsl_pkg::CH_W-1:0]   red,
    input  logic [rgbhsl_pkg::CH_W-1:0]   green,
    input  logic [rgbhsl_pkg::CH_W-1:0]   blue,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rgbhsl_pkg::OUT_W-1:0]  hue,
    output logic [rgbhsl_pkg::OUT_W-1:0]  saturation,
    output logic [rgbhsl_pkg::OUT_W-1:0]  lightness,
    output logic                          gray
);
    import rgbhsl_pkg::*;

    logic   en;
    logic   valid_chain [QUO_W+1];
    stage_t data_chain  [QUO_W+1];

    assign en       = out_ready || !out_valid;
    assign in_ready = en;

    rgbhsl_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (valid_chain[0]),
        .out_data  (data_chain[0])
    );

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_cell
        rgbhsl_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (valid_chain[i]),
            .in_data   (data_chain[i]),
            .out_valid (valid_chain[i+1]),
            .out_data  (data_chain[i+1])
        );
    end

    // quotients sit in the low bits once every cell has run
    assign out_valid  = valid_chain[QUO_W];
    assign gray       = data_chain[QUO_W].gray;
    assign hue        = gray ? '0 : data_chain[QUO_W].hue_w[OUT_W-1:0];
    assign saturation = gray ? '0 : data_chain[QUO_W].sat_w[OUT_W-1:0];
    assign lightness  = data_chain[QUO_W].lit;

    a_hue_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hue < OUT_W'(HUE_FULL)))
        else $error("hue out of range");

    a_sat_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (saturation <= OUT_W'(PCT_SCALE)))
        else $error("saturation out of range");

    a_lit_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (lightness <= OUT_W'(PCT_SCALE)))
        else $error("lightness out of range");

    a_gray_sat : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !gray) |-> (saturation != '0))
        else $error("colored pixel with zero saturation");

endmodule
